@@ design/owbm_pkg.sv @@
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int CFG_W    = 10;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef enum logic [IDX_W-1:0] {
        REG_RESET_LOW      = 3'd0,
        REG_PRESENCE_SAMPLE = 3'd1,
        REG_RESET_TAIL     = 3'd2,
        REG_SLOT           = 3'd3,
        REG_SHORT_LOW      = 3'd4,
        REG_READ_SAMPLE    = 3'd5,
        REG_WRITE0_LOW     = 3'd6,
        REG_RECOVERY       = 3'd7
    } reg_idx_t;

    localparam cfg_word_t REG_RESET_VALS [NUM_REGS] = '{
        10'd480, 10'd70, 10'd410, 10'd70, 10'd6, 10'd9, 10'd70, 10'd1
    };

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_RST_LOW  = 6'b000010,
        PH_RST_WAIT = 6'b000100,
        PH_RST_TAIL = 6'b001000,
        PH_SLOT     = 6'b010000,
        PH_RECOV    = 6'b100000
    } phase_t;

endpackage

@@ design/one_wire_bus_master.sv @@
`timescale 1ns / 1ps
// Items pass the input register, then the output register; one item per cycle unless
// the output stalls, and the tick state machine updates once per item.
// Reset: synchronous on aresetn low; the machine returns to idle, presence and the
// last read byte clear, and all timing registers take their default values.
// There is no clearing pass; the block takes items on the first cycle after reset.
module one_wire_bus_master #(
    parameter int TIME_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // tx_byte[7:0], line_in[8]
    input  logic [1:0]                      s_tuser,   // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // drive_low[0], busy_res[1],
                                                       // done_res[2], presence[3],
                                                       // rx_byte[11:4], cmd_ignored[12]
    input  logic                            cfg_wr_en,
    input  logic [owbm_pkg::IDX_W-1:0]      cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]      cfg_wdata
);
    import owbm_pkg::*;

    localparam int EW = (TIME_BITS < CFG_W) ? TIME_BITS : CFG_W;
    localparam int CW = TIME_BITS + 1;

    cfg_word_t cfg_reg [NUM_REGS];

    logic                 in_valid_reg;
    req_t                 in_req_reg;
    logic [7:0]           in_tx_reg;
    logic                 in_line_reg;

    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [2:0]           bit_idx_reg, bit_idx_next;
    logic [7:0]           shift_reg, shift_next;
    req_t                 op_reg, op_next;
    logic                 pres_reg, pres_next;
    logic [7:0]           rx_reg, rx_next;

    logic                 out_valid_reg;
    logic [15:0]          out_data_reg, out_data_next;

    logic                 advance;

    logic [CW-1:0] t_rst_low, t_pres, t_tail, t_slot, t_short, t_rsamp, t_w0, t_recov;

    function automatic logic [CW-1:0] at_least(input cfg_word_t v, input logic [CW-1:0] lo);
        logic [CW-1:0] e;
        e = CW'(v[EW-1:0]);
        return (e < lo) ? lo : e;
    endfunction

    assign t_rst_low = at_least(cfg_reg[REG_RESET_LOW], CW'(1));
    assign t_pres    = at_least(cfg_reg[REG_PRESENCE_SAMPLE], CW'(1));
    assign t_tail    = at_least(cfg_reg[REG_RESET_TAIL], CW'(1));
    assign t_slot    = at_least(cfg_reg[REG_SLOT], CW'(2));
    assign t_short   = at_least(cfg_reg[REG_SHORT_LOW], CW'(1));
    assign t_rsamp   = at_least(cfg_reg[REG_READ_SAMPLE], CW'(1));
    assign t_w0      = at_least(cfg_reg[REG_WRITE0_LOW], CW'(1));
    assign t_recov   = at_least(cfg_reg[REG_RECOVERY], CW'(0));

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= REG_RESET_VALS[i];
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= req_t'(s_tuser);
            in_tx_reg   <= s_tdata[7:0];
            in_line_reg <= s_tdata[8];
        end
    end

    always_comb begin
        logic          drive, done, ignored, active, bit_end, bitv;
        logic [CW-1:0] inc, low, samp;

        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        op_next      = op_reg;
        pres_next    = pres_reg;
        rx_next      = rx_reg;
        drive        = 1'b0;
        done         = 1'b0;
        ignored      = 1'b0;
        active       = 1'b0;
        bit_end      = 1'b0;
        bitv         = 1'b0;
        inc          = '0;
        low          = '0;
        samp         = '0;

        if (phase_next == PH_IDLE) begin
            if (in_req_reg != REQ_NONE) begin
                op_next      = in_req_reg;
                tick_next    = '0;
                bit_idx_next = '0;
                if (in_req_reg == REQ_RESET) begin
                    phase_next = PH_RST_LOW;
                    shift_next = '0;
                end else begin
                    phase_next = PH_SLOT;
                    shift_next = (in_req_reg == REQ_WRITE) ? in_tx_reg : 8'd0;
                end
            end
        end else if (in_req_reg != REQ_NONE) begin
            ignored = 1'b1;
        end

        if (phase_next != PH_IDLE) begin
            active = 1'b1;
            inc    = CW'(tick_next) + CW'(1);
            unique case (phase_next)
                PH_RST_LOW: begin
                    drive     = 1'b1;
                    tick_next = inc[TIME_BITS-1:0];
                    if (inc >= t_rst_low) begin
                        phase_next = PH_RST_WAIT;
                        tick_next  = '0;
                    end
                end
                PH_RST_WAIT: begin
                    tick_next = inc[TIME_BITS-1:0];
                    if (inc >= t_pres) begin
                        pres_next  = !in_line_reg;
                        phase_next = PH_RST_TAIL;
                        tick_next  = '0;
                    end
                end
                PH_RST_TAIL: begin
                    tick_next = inc[TIME_BITS-1:0];
                    if (inc >= t_tail) begin
                        done = 1'b1;
                    end
                end
                PH_SLOT: begin
                    bitv = shift_next[bit_idx_next];
                    low  = (op_next == REQ_WRITE && !bitv) ? t_w0 : t_short;
                    if (low > t_slot) begin
                        low = t_slot;
                    end
                    drive = (CW'(tick_next) < low);
                    if (op_next == REQ_READ) begin
                        samp = low + t_rsamp - CW'(1);
                        if (samp > t_slot - CW'(1)) begin
                            samp = t_slot - CW'(1);
                        end
                        if (CW'(tick_next) == samp) begin
                            shift_next[bit_idx_next] = shift_next[bit_idx_next] | in_line_reg;
                        end
                    end
                    tick_next = inc[TIME_BITS-1:0];
                    if (inc >= t_slot) begin
                        tick_next = '0;
                        if (t_recov != '0) begin
                            phase_next = PH_RECOV;
                        end else begin
                            bit_end = 1'b1;
                        end
                    end
                end
                PH_RECOV: begin
                    tick_next = inc[TIME_BITS-1:0];
                    if (inc >= t_recov) begin
                        bit_end = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (bit_end) begin
                if (bit_idx_next == 3'd7) begin
                    done = 1'b1;
                end else begin
                    bit_idx_next = bit_idx_next + 3'd1;
                    phase_next   = PH_SLOT;
                    tick_next    = '0;
                end
            end

            if (done) begin
                if (op_next == REQ_READ) begin
                    rx_next = shift_next;
                end
                phase_next   = PH_IDLE;
                tick_next    = '0;
                bit_idx_next = '0;
            end
        end

        out_data_next = {3'd0, ignored, rx_next, pres_next, done, active && !done, drive};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            op_reg      <= REQ_NONE;
            pres_reg    <= 1'b0;
            rx_reg      <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            op_reg      <= op_next;
            pres_reg    <= pres_next;
            rx_reg      <= rx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ sim/one_wire_bus_master_test.sv @@
`timescale 1ns / 1ps

module one_wire_bus_master_test;

    import owbm_pkg::*;

    localparam int TIME_BITS = 10;

    typedef struct packed {
        logic       cmd_ignored;
        logic [7:0] rx_byte;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } bus_status_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;   // tx_byte[7:0], line_in[8]
    logic [1:0]            s_tuser = '0;   // req_type[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;        // drive_low[0], busy_res[1], done_res[2],
                                           // presence[3], rx_byte[11:4], cmd_ignored[12]
    logic                  cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    one_wire_bus_master #(.TIME_BITS(TIME_BITS)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predicted state of the bus master.
    cfg_word_t   timing_regs [NUM_REGS];
    phase_t      bus_phase;
    int          tick_cnt;
    logic [2:0]  bit_idx;
    logic [7:0]  shift_bits;
    req_t        op_kind;
    logic        presence_q;
    logic [7:0]  rx_last;

    bus_status_t expected_status [$];

    // Simulated slave on the bus.
    logic        slave_present = 1'b1;
    logic [7:0]  slave_byte = 8'h00;

    bit          idle_on = 1'b1;
    int          hold_cycles = 0;
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          dropped_seen = 0;
    int          n_reset = 0;
    int          n_write = 0;
    int          n_read = 0;

    function automatic int timing_of(reg_idx_t idx, int floor_val);
        int v;
        v = int'(timing_regs[idx]) & ((1 << TIME_BITS) - 1);
        return (v < floor_val) ? floor_val : v;
    endfunction

    task automatic step_bus(input req_t req, input logic [7:0] txb, input logic line,
                            output bus_status_t res);
        int   slot_len;
        int   low_len;
        int   samp;
        logic drive;
        logic done;
        logic ignored;
        logic active;
        logic bit_end;
        drive = 1'b0;
        done = 1'b0;
        ignored = 1'b0;
        active = 1'b0;
        bit_end = 1'b0;
        if (bus_phase == PH_IDLE) begin
            if (req != REQ_NONE) begin
                op_kind = req;
                tick_cnt = 0;
                bit_idx = 3'd0;
                case (req)
                    REQ_RESET: n_reset++;
                    REQ_WRITE: n_write++;
                    default:   n_read++;
                endcase
                if (req == REQ_RESET) begin
                    bus_phase = PH_RST_LOW;
                    shift_bits = 8'h00;
                end else begin
                    bus_phase = PH_SLOT;
                    shift_bits = (req == REQ_WRITE) ? txb : 8'h00;
                end
            end
        end else if (req != REQ_NONE) begin
            ignored = 1'b1;
        end

        if (bus_phase != PH_IDLE) begin
            active = 1'b1;
            case (bus_phase)
                PH_RST_LOW: begin
                    drive = 1'b1;
                    tick_cnt++;
                    if (tick_cnt >= timing_of(REG_RESET_LOW, 1)) begin
                        bus_phase = PH_RST_WAIT;
                        tick_cnt = 0;
                    end
                end
                PH_RST_WAIT: begin
                    tick_cnt++;
                    if (tick_cnt >= timing_of(REG_PRESENCE_SAMPLE, 1)) begin
                        presence_q = !line;
                        bus_phase = PH_RST_TAIL;
                        tick_cnt = 0;
                    end
                end
                PH_RST_TAIL: begin
                    tick_cnt++;
                    if (tick_cnt >= timing_of(REG_RESET_TAIL, 1))
                        done = 1'b1;
                end
                PH_SLOT: begin
                    slot_len = timing_of(REG_SLOT, 2);
                    if (op_kind == REQ_WRITE && !shift_bits[bit_idx])
                        low_len = timing_of(REG_WRITE0_LOW, 1);
                    else
                        low_len = timing_of(REG_SHORT_LOW, 1);
                    if (low_len > slot_len)
                        low_len = slot_len;
                    drive = (tick_cnt < low_len);
                    if (op_kind == REQ_READ) begin
                        samp = low_len + timing_of(REG_READ_SAMPLE, 1) - 1;
                        if (samp > slot_len - 1)
                            samp = slot_len - 1;
                        if (tick_cnt == samp)
                            shift_bits[bit_idx] = shift_bits[bit_idx] | line;
                    end
                    tick_cnt++;
                    if (tick_cnt >= slot_len) begin
                        tick_cnt = 0;
                        if (timing_of(REG_RECOVERY, 0) > 0)
                            bus_phase = PH_RECOV;
                        else
                            bit_end = 1'b1;
                    end
                end
                default: begin
                    tick_cnt++;
                    if (tick_cnt >= timing_of(REG_RECOVERY, 0))
                        bit_end = 1'b1;
                end
            endcase

            if (bit_end) begin
                if (bit_idx == 3'd7) begin
                    done = 1'b1;
                end else begin
                    bit_idx++;
                    bus_phase = PH_SLOT;
                    tick_cnt = 0;
                end
            end

            if (done) begin
                if (op_kind == REQ_READ)
                    rx_last = shift_bits;
                bus_phase = PH_IDLE;
                tick_cnt = 0;
                bit_idx = 3'd0;
            end
        end

        res.drive_low = drive;
        res.busy_res = active && !done;
        res.done_res = done;
        res.presence = presence_q;
        res.rx_byte = rx_last;
        res.cmd_ignored = ignored;
    endtask

    // The slave answers presence and read slots; elsewhere the bus is mostly high.
    // A rare flip adds line noise.
    function automatic logic slave_line();
        logic lvl;
        if (bus_phase == PH_RST_WAIT)
            lvl = !slave_present;
        else if (bus_phase == PH_SLOT && op_kind == REQ_READ)
            lvl = slave_byte[bit_idx];
        else
            lvl = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 31) == 0)
            lvl = !lvl;
        return lvl;
    endfunction

    task automatic send_item(input req_t req, input logic [7:0] txb);
        logic        line;
        bus_status_t want;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        line = slave_line();
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, line, txb};
        s_tuser <= req;
        do @(posedge aclk); while (!s_tready);
        step_bus(req, txb, line, want);
        expected_status.push_back(want);
        items_sent++;
    endtask

    task automatic finish_command(input int flood_pct);
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < flood_pct)
                send_item(req_t'($urandom_range(1, 3)), 8'($urandom));
            else
                send_item(REQ_NONE, 8'($urandom));
        end
    endtask

    task automatic run_command(input req_t req, input logic [7:0] txb, input int flood_pct);
        if (bus_phase != PH_IDLE)
            finish_command(0);
        send_item(req, txb);
        finish_command(flood_pct);
    endtask

    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= cfg_word_t'(value);
        timing_regs[idx] = cfg_word_t'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_timing(input int rst_low, input int pres, input int tail,
                               input int slot, input int short_low, input int rsamp,
                               input int w0_low, input int recov);
        write_reg(REG_RESET_LOW, rst_low);
        write_reg(REG_PRESENCE_SAMPLE, pres);
        write_reg(REG_RESET_TAIL, tail);
        write_reg(REG_SLOT, slot);
        write_reg(REG_SHORT_LOW, short_low);
        write_reg(REG_READ_SAMPLE, rsamp);
        write_reg(REG_WRITE0_LOW, w0_low);
        write_reg(REG_RECOVERY, recov);
    endtask

    task automatic load_defaults();
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(reg_idx_t'(i), int'(REG_RESET_VALS[i]));
    endtask

    function automatic int rand_time(int lo, int hi);
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(lo, hi);
    endfunction

    // Each command starts on the default timings, then short timings finish it.
    task automatic test_default_timing();
        idle_on = 1'b0;
        slave_present = 1'b1;
        send_item(REQ_RESET, 8'h00);
        repeat (24) send_item(REQ_NONE, 8'h00);
        drain_pipeline();
        load_timing(1, 3, 3, 4, 1, 2, 3, 1);
        finish_command(0);
        drain_pipeline();
        load_defaults();
        send_item(REQ_WRITE, 8'hA4);
        repeat (74) send_item(REQ_NONE, 8'h00);
        drain_pipeline();
        load_timing(1, 3, 3, 4, 1, 2, 3, 1);
        finish_command(0);
        drain_pipeline();
        load_defaults();
        slave_byte = 8'h3C;
        send_item(REQ_READ, 8'h00);
        repeat (39) send_item(REQ_NONE, 8'h00);
        drain_pipeline();
        load_timing(1, 3, 3, 4, 1, 2, 3, 1);
        finish_command(0);
        drain_pipeline();
        idle_on = 1'b1;
    endtask

    // Zero register values must act as the smallest legal timing.
    task automatic test_minimum_timing();
        load_timing(0, 0, 0, 0, 0, 0, 0, 0);
        slave_present = 1'b0;
        send_item(REQ_NONE, 8'hFF);
        run_command(REQ_RESET, 8'h00, 0);
        run_command(REQ_WRITE, 8'h00, 0);
        run_command(REQ_WRITE, 8'hFF, 0);
        slave_byte = 8'h00;
        run_command(REQ_READ, 8'hFF, 0);
        slave_byte = 8'hFF;
        run_command(REQ_READ, 8'h00, 0);
        drain_pipeline();
    endtask

    // Every busy tick, the done tick included, carries a command that must be dropped.
    task automatic test_busy_commands();
        load_timing(2, 2, 2, 3, 1, 1, 5, 1);
        slave_present = 1'b1;
        run_command(REQ_RESET, 8'h00, 100);
        run_command(REQ_WRITE, 8'h5A, 100);
        slave_byte = 8'hC3;
        run_command(REQ_READ, 8'h00, 100);
        drain_pipeline();
    endtask

    // Shrinking timings mid-command ends the current phase or skips a read sample.
    task automatic test_config_mid_command();
        load_timing(3, 3, 3, 8, 2, 3, 5, 2);
        slave_byte = 8'hFF;
        send_item(REQ_READ, 8'h00);
        repeat (3) send_item(REQ_NONE, 8'h00);
        drain_pipeline();
        write_reg(REG_READ_SAMPLE, 1);
        write_reg(REG_SLOT, 2);
        finish_command(0);
        drain_pipeline();
        load_timing(6, 3, 3, 4, 1, 1, 2, 3);
        send_item(REQ_RESET, 8'h00);
        repeat (3) send_item(REQ_NONE, 8'h00);
        drain_pipeline();
        write_reg(REG_RESET_LOW, 1);
        finish_command(0);
        send_item(REQ_WRITE, 8'h00);
        repeat (5) send_item(REQ_NONE, 8'h00);
        drain_pipeline();
        write_reg(REG_RECOVERY, 0);
        finish_command(0);
        drain_pipeline();
    endtask

    // Low times beyond the slot fill the whole slot, so reads sample while driving low.
    // The largest read sample value also pushes the sample point sum past the slot end.
    task automatic test_capped_timing();
        load_timing(3, 2, 2, 5, 1023, 1023, 1023, 1);
        slave_present = 1'b1;
        run_command(REQ_RESET, 8'h00, 0);
        slave_byte = 8'($urandom);
        run_command(REQ_READ, 8'h00, 0);
        run_command(REQ_WRITE, 8'h96, 0);
        drain_pipeline();
    endtask

    task automatic test_backpressure();
        load_timing(2, 2, 2, 6, 2, 2, 4, 1);
        hold_cycles = 300;
        repeat (2) begin
            slave_byte = 8'($urandom);
            run_command(req_t'($urandom_range(1, 3)), 8'($urandom), 4);
        end
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < 150) begin
            load_timing(rand_time(1, 12), rand_time(1, 8), rand_time(1, 10), rand_time(2, 6),
                        rand_time(1, 4), rand_time(1, 6), rand_time(1, 8),
                        $urandom_range(0, 2));
            repeat ($urandom_range(2, 4)) begin
                repeat ($urandom_range(0, 3)) send_item(REQ_NONE, 8'($urandom));
                if ($urandom_range(0, 99) < 85) begin
                    slave_present = 1'($urandom_range(0, 1));
                    slave_byte = 8'($urandom);
                    run_command(req_t'($urandom_range(1, 3)), 8'($urandom), 4);
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item(req_t'($urandom_range(0, 3)), 8'($urandom));
                    finish_command(10);
                end
            end
            drain_pipeline();
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= !(idle_on && $urandom_range(0, 99) < 6);
        end
    end

    always @(posedge aclk) begin : check_results
        bus_status_t got;
        bus_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = bus_status_t'(m_tdata[12:0]);
            results_seen++;
            if (got.cmd_ignored === 1'b1)
                dropped_seen++;
            if (expected_status.size() == 0) begin
                $error("Result item arrived with nothing expected.");
                errors++;
            end else begin
                want = expected_status.pop_front();
                compare_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
                compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
                compare_field("presence", 8'(want.presence), 8'(got.presence));
                compare_field("rx_byte", want.rx_byte, got.rx_byte);
                compare_field("cmd_ignored", 8'(want.cmd_ignored), 8'(got.cmd_ignored));
            end
        end
    end

    initial begin
        #1000000;
        $display("one_wire_bus_master test failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++)
            timing_regs[i] = REG_RESET_VALS[i];
        bus_phase = PH_IDLE;
        tick_cnt = 0;
        bit_idx = 3'd0;
        shift_bits = 8'h00;
        op_kind = REQ_NONE;
        presence_q = 1'b0;
        rx_last = 8'h00;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_timing();
        test_minimum_timing();
        test_busy_commands();
        test_config_mid_command();
        test_capped_timing();
        test_backpressure();
        test_random_traffic();

        drain_pipeline();
        repeat (8) @(posedge aclk);
        $display("Sent %0d ticks: %0d resets, %0d writes, %0d reads started, %0d dropped.",
                 items_sent, n_reset, n_write, n_read, dropped_seen);
        $display("Checked %0d result items across default, minimum, capped and random timings.",
                 results_seen);
        if (errors == 0)
            $display("one_wire_bus_master test passed");
        else
            $display("one_wire_bus_master test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/owbm_pkg.sv
design/one_wire_bus_master.sv
sim/one_wire_bus_master_test.sv
